@@ src/rfa_pkg.sv @@
package rfa_pkg;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_FORM,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_DONE
	} state_t;

	localparam int unsigned PROD_W = 64;

endpackage

@@ src/reduced_fraction_alu.sv @@
// Channel   Dir  Beat contents
// s_axis    in   tdata: command, first_numerator, first_denominator,
//                       second_numerator, second_denominator
// m_axis    out  tdata: result_numerator, result_denominator; tuser: status
//
// One shared multiplier forms the cross products in ST_MUL1, ST_MUL2 and, for
// add and subtract, ST_MUL3; one shared subtract/compare unit runs a binary gcd
// (one step a cycle), then restoring division of numerator and denominator by
// the gcd, one quotient bit a cycle.
// Reset is asynchronous and clears control; s_axis_tready is low while busy.
// The result holds in the output register until m_axis_tready takes it.
module reduced_fraction_alu
	import rfa_pkg::*;
#(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// command, first_numerator, first_denominator, second_numerator,
	// second_denominator, zero fill
	input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// result_numerator [31:0], result_denominator [62:32], zero fill
	output logic [63:0] m_axis_tdata,
	// status
	output logic m_axis_tuser
);

	localparam int OW = OPERAND_WIDTH;
	localparam int DW = OW - 1;
	// product magnitude width
	localparam int PW = 2 * OW + 1;
	localparam int CW = $clog2(PW + 1);

	// field unpack
	logic [1:0] cmd_in;
	logic signed [OW-1:0] n1_in, n2_in;
	logic [DW-1:0] d1_in, d2_in;
	assign cmd_in = s_axis_tdata[1:0];
	assign n1_in = s_axis_tdata[2 +: OW];
	assign d1_in = s_axis_tdata[2+OW +: DW];
	assign n2_in = s_axis_tdata[1+2*OW +: OW];
	assign d2_in = s_axis_tdata[1+3*OW +: DW];

	state_t state_q, state_d;
	cmd_t cmd_q;
	logic signed [OW-1:0] n1_q, n2_q;
	logic [DW-1:0] d1_q, d2_q;
	logic signed [2*OW:0] p0_q, p1_q, p2_q;
	logic [PW-1:0] mag_q, den_q, ga_q, gb_q, rem_q, quo_q, divd_q;
	logic [CW-1:0] k_q, cnt_q;
	logic neg_q, err_q;
	logic [31:0] rn_q;
	logic [30:0] rd_q;
	logic out_v_q;
	logic [31:0] out_num_q;
	logic [30:0] out_den_q;
	logic out_err_q;

	// shared multiplier operands
	logic signed [OW:0] ma, mb;
	logic signed [2*OW+1:0] mp;
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			ST_MUL1: begin
				ma = {n1_q[OW-1], n1_q};
				mb = (cmd_q == CMD_MUL) ? {n2_q[OW-1], n2_q} : {2'b00, d2_q};
			end
			ST_MUL2: begin
				ma = {2'b00, d1_q};
				mb = (cmd_q == CMD_MUL) ? {2'b00, d2_q} :
					(cmd_q == CMD_DIV) ? {n2_q[OW-1], n2_q} : {2'b00, d2_q};
			end
			ST_MUL3: begin
				ma = {2'b00, d1_q};
				mb = {n2_q[OW-1], n2_q};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end
	assign mp = ma * mb;

	// shared subtract unit
	logic [PW:0] sub_a, sub_b, diff;
	always_comb begin
		sub_a = '0;
		sub_b = '0;
		unique case (state_q)
			ST_GCD: begin
				sub_a = {1'b0, (ga_q > gb_q) ? ga_q : gb_q};
				sub_b = {1'b0, (ga_q > gb_q) ? gb_q : ga_q};
			end
			ST_DIVN, ST_DIVD: begin
				sub_a = {rem_q, divd_q[PW-1]};
				sub_b = {1'b0, ga_q};
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end
	assign diff = sub_a - sub_b;

	logic gcd_done;
	assign gcd_done = (ga_q == '0) || (gb_q == '0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = (cmd_q == CMD_ADD || cmd_q == CMD_SUB) ? ST_MUL3 : ST_FORM;
			ST_MUL3: state_d = ST_FORM;
			ST_FORM: state_d = err_q ? ST_DONE : ST_GCD;
			ST_GCD: if (gcd_done) state_d = ST_DIVN;
			ST_DIVN: if (cnt_q == CW'(PW - 1)) state_d = ST_DIVD;
			ST_DIVD: if (cnt_q == CW'(PW - 1)) state_d = ST_DONE;
			ST_DONE: if (!out_v_q || m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		m_axis_tvalid = out_v_q;
		m_axis_tdata = {1'b0, out_den_q, out_num_q};
		m_axis_tuser = out_err_q;
	end

	// control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			out_num_q <= '0;
			out_den_q <= '0;
			out_err_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && (!out_v_q || m_axis_tready)) begin
				out_v_q <= 1'b1;
				out_num_q <= rn_q;
				out_den_q <= rd_q;
				out_err_q <= err_q;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q <= cmd_t'(cmd_in);
				n1_q <= n1_in;
				n2_q <= n2_in;
				d1_q <= d1_in;
				d2_q <= d2_in;
				err_q <= (d1_in == '0) || (d2_in == '0) ||
					(cmd_t'(cmd_in) == CMD_DIV && n2_in == '0);
			end
			ST_MUL1: p0_q <= mp[2*OW:0];
			ST_MUL2: p1_q <= mp[2*OW:0];
			ST_MUL3: p2_q <= mp[2*OW:0];
			ST_FORM: begin
				logic signed [PW:0] nv, dv;
				nv = '0;
				dv = '0;
				unique case (cmd_q)
					CMD_ADD: begin
						nv = (PW+1)'(p0_q) + (PW+1)'(p2_q);
						dv = (PW+1)'(p1_q);
					end
					CMD_SUB: begin
						nv = (PW+1)'(p0_q) - (PW+1)'(p2_q);
						dv = (PW+1)'(p1_q);
					end
					CMD_MUL: begin
						nv = (PW+1)'(p0_q);
						dv = (PW+1)'(p1_q);
					end
					CMD_DIV: begin
						nv = (p1_q < 0) ? -(PW+1)'(p0_q) : (PW+1)'(p0_q);
						dv = (p1_q < 0) ? -(PW+1)'(p1_q) : (PW+1)'(p1_q);
					end
					default: begin
						nv = '0;
						dv = '0;
					end
				endcase
				neg_q <= nv[PW];
				mag_q <= nv[PW] ? PW'(-nv) : nv[PW-1:0];
				den_q <= dv[PW-1:0];
				ga_q <= nv[PW] ? PW'(-nv) : nv[PW-1:0];
				gb_q <= dv[PW-1:0];
				k_q <= '0;
				if (err_q) begin
					rn_q <= '0;
					rd_q <= '0;
				end
			end
			ST_GCD: begin
				// binary gcd: strip common twos, then subtract odd values
				if (gcd_done) begin
					ga_q <= (ga_q | gb_q) << k_q;
					divd_q <= mag_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else begin
					ga_q <= sub_b[PW-1:0];
					gb_q <= diff[PW:1];
				end
			end
			ST_DIVN, ST_DIVD: begin
				// restoring division, one quotient bit a cycle
				logic [PW-1:0] nr, qf;
				logic qb;
				qb = !diff[PW];
				nr = qb ? diff[PW-1:0] : sub_a[PW-1:0];
				qf = {quo_q[PW-2:0], qb};
				quo_q <= qf;
				if (cnt_q == CW'(PW - 1)) begin
					cnt_q <= '0;
					rem_q <= '0;
					if (state_q == ST_DIVN) begin
						rn_q <= neg_q ? -(32'(qf)) : 32'(qf);
						divd_q <= den_q;
					end else begin
						rd_q <= 31'(qf);
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
					rem_q <= nr;
					divd_q <= divd_q << 1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ src/rfa_checker.sv @@
module rfa_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic m_axis_tuser
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");

	// a result without error status has a nonzero denominator
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[62:32] != 31'd0)
		else $error("zero denominator");

	// an error result is zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 64'd0)
		else $error("error result not zero");

	// not ready right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted while busy");

endmodule

bind reduced_fraction_alu rfa_checker u_rfa_checker (.*);

@@ bench/fraction_checker.sv @@
`timescale 1ns / 100ps

// Watches both streams, predicts each reduced fraction and compares.
module fraction_checker
	import rfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	output int          mismatches,
	output int          pending,
	output int          operands_seen,
	output int          results_seen,
	output int          div_errors
);

	typedef struct packed {
		logic [31:0] num;
		logic [30:0] den;
		logic        status;
	} fraction_t;

	fraction_t reduced_q[$];

	function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
		longint unsigned t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	// exact cross-multiplied result, reduced by gcd of magnitudes
	function automatic fraction_t reduce_fraction(logic [63:0] beat);
		cmd_t            cmd;
		longint          n1, d1, n2, d2, num, den;
		longint unsigned mag, dm, g;
		fraction_t       r;
		cmd = cmd_t'(beat[1:0]);
		n1  = longint'($signed(beat[17:2]));
		d1  = longint'(beat[32:18]);
		n2  = longint'($signed(beat[48:33]));
		d2  = longint'(beat[63:49]);
		r   = '{num: '0, den: '0, status: 1'b1};
		if (d1 == 0 || d2 == 0)
			return r;
		case (cmd)
			CMD_ADD: begin
				num = n1 * d2 + d1 * n2;
				den = d1 * d2;
			end
			CMD_SUB: begin
				num = n1 * d2 - d1 * n2;
				den = d1 * d2;
			end
			CMD_MUL: begin
				num = n1 * n2;
				den = d1 * d2;
			end
			default: begin
				if (n2 == 0)
					return r;
				num = n1 * d2;
				den = d1 * n2;
				if (den < 0) begin
					num = -num;
					den = -den;
				end
			end
		endcase
		mag = (num < 0) ? longint'(-num) : longint'(num);
		dm  = den;
		g   = euclid(mag, dm);
		mag = mag / g;
		dm  = dm / g;
		r.num    = (num < 0) ? 32'(-mag) : 32'(mag);
		r.den    = 31'(dm);
		r.status = 1'b0;
		return r;
	endfunction

	// predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		fraction_t exp_r, got;
		if (!arst_n) begin
			mismatches    <= 0;
			pending       <= 0;
			operands_seen <= 0;
			results_seen  <= 0;
			div_errors    <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				exp_r = reduce_fraction(s_axis_tdata);
				reduced_q.push_back(exp_r);
				operands_seen <= operands_seen + 1;
				if (exp_r.status)
					div_errors <= div_errors + 1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{num: m_axis_tdata[31:0], den: m_axis_tdata[62:32],
					status: m_axis_tuser};
				results_seen <= results_seen + 1;
				if (reduced_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result %0d/%0d status %0b", $realtime,
							$signed(got.num), got.den, got.status);
					mismatches <= mismatches + 1;
				end else begin
					exp_r = reduced_q.pop_front();
					if (got !== exp_r) begin
						if (mismatches < 10)
							$display("%0t: expected %0d/%0d status %0b, got %0d/%0d status %0b",
								$realtime, $signed(exp_r.num), exp_r.den, exp_r.status,
								$signed(got.num), got.den, got.status);
						mismatches <= mismatches + 1;
					end
				end
			end
			pending <= reduced_q.size();
		end
	end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb
	import rfa_pkg::*;
;

	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_LEN   = 3000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tuser;

	int mismatches, pending, operands_seen, results_seen, div_errors;
	int send_idle_pct, recv_stall_pct, hold_cycles, quiet_cycles;

	reduced_fraction_alu dut (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
	);

	fraction_checker chk (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
		.mismatches, .pending, .operands_seen, .results_seen, .div_errors
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// result side: random stalls plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] pack_operands(cmd_t cmd, logic [15:0] n1, logic [14:0] d1,
		logic [15:0] n2, logic [14:0] d2);
		return {d2, n2, d1, n1, cmd};
	endfunction

	// numerator: small, full range or an extreme
	function automatic logic [15:0] rand_num();
		int unsigned k;
		k = $urandom_range(9);
		if (k < 5)
			return 16'($signed($urandom_range(40)) - 20);
		else if (k < 9)
			return 16'($urandom);
		else
			return ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
	endfunction

	// denominator: mostly valid, now and then zero
	function automatic logic [14:0] rand_den();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 3)
			return 15'd0;
		else if (k < 50)
			return 15'($urandom_range(24, 1));
		else if (k < 95)
			return 15'($urandom_range(32767, 1));
		else
			return 15'h7fff;
	endfunction

	// drive one beat; valid stays up unless a gap is drawn
	task automatic send(logic [63:0] beat);
		int unsigned gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= beat;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(6, 1);
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_random();
		send(pack_operands(cmd_t'($urandom_range(3)), rand_num(), rand_den(),
			rand_num(), rand_den()));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		m_axis_tready  = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = 0;
		quiet_cycles   = 0;
		arst_n         = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, every command, error and zero cases
		send(pack_operands(CMD_ADD, 16'sd1, 15'd2, 16'sd1, 15'd3));
		send(pack_operands(CMD_SUB, 16'sd1, 15'd2, 16'sd1, 15'd2));
		send(pack_operands(CMD_MUL, 16'sd0, 15'd7, 16'sd5, 15'd9));
		send(pack_operands(CMD_DIV, 16'sd3, 15'd4, -16'sd3, 15'd8));
		send(pack_operands(CMD_DIV, 16'sd5, 15'd3, 16'sd0, 15'd1));
		send(pack_operands(CMD_ADD, 16'sd1, 15'd0, 16'sd1, 15'd1));
		send(pack_operands(CMD_MUL, 16'sd1, 15'd1, 16'sd1, 15'd0));
		send(pack_operands(CMD_DIV, 16'sd1, 15'd0, 16'sd0, 15'd0));
		send(pack_operands(CMD_ADD, 16'h8000, 15'h7fff, 16'h8000, 15'h7fff));
		send(pack_operands(CMD_ADD, 16'h7fff, 15'h7fff, 16'h7fff, 15'h7ffe));
		send(pack_operands(CMD_SUB, 16'h8000, 15'h7fff, 16'h7fff, 15'h7ffe));
		send(pack_operands(CMD_SUB, 16'h7fff, 15'd1, 16'h8000, 15'd1));
		send(pack_operands(CMD_MUL, 16'h8000, 15'd1, 16'h8000, 15'd1));
		send(pack_operands(CMD_MUL, 16'h7fff, 15'h7fff, 16'h8000, 15'h7ffe));
		send(pack_operands(CMD_DIV, 16'h8000, 15'd1, -16'sd1, 15'h7fff));
		send(pack_operands(CMD_DIV, 16'h8000, 15'h7fff, 16'h8000, 15'd1));
		send(pack_operands(CMD_DIV, 16'h7fff, 15'd1, 16'sd1, 15'h7fff));
		send(pack_operands(CMD_ADD, -16'sd4, 15'd6, 16'sd2, 15'd3));
		send(pack_operands(CMD_SUB, 16'sd0, 15'd1, 16'sd0, 15'd5));
		send(pack_operands(CMD_MUL, -16'sd6, 15'd4, -16'sd2, 15'd9));

		// long result hold-off while operands keep coming
		hold_cycles = HOLD_LEN;
		repeat (6) send_random();
		// pause until every result is back
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			repeat (230) send_random();
		end

		drain();
		repeat (400) @(negedge clk);
		$display("Covered %0d operand beats and %0d results (%0d error results)",
			operands_seen, results_seen, div_errors);
		$display("across four idle/stall mixes and one long result hold-off");
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
